// File: rtl/rbaabb_pkg.sv
// shared types, constants and helpers for the rotated box to aabb block
package rbaabb_pkg;

	localparam int QUAT_W  = 16;
	localparam int EXT_W   = 24;
	localparam int PROD_W  = 2 * QUAT_W;
	localparam int ENT_W   = PROD_W + 3;
	localparam int MAG_W   = PROD_W + 1;
	localparam int WPROD_W = MAG_W + EXT_W;
	localparam int SUM_W   = WPROD_W + 2;
	localparam int FRAC_W  = 28;
	localparam int MAX_W   = 25;
	localparam int MIN_W   = 26;
	localparam int SHIFT_W = SUM_W - FRAC_W;
	localparam int IN_DATA_W  = 4 * QUAT_W;
	localparam int OUT_FLDS_W = 3 * MIN_W + 3 * MAX_W;
	localparam int OUT_DATA_W = ((OUT_FLDS_W + 7) / 8) * 8;

	localparam logic signed [ENT_W-1:0] ENT_ONE = ENT_W'(64'sd1 << FRAC_W);
	localparam logic [MAX_W-1:0] MAX_OUT = {MAX_W{1'b1}};
	localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(256);

	// configuration register indexes
	localparam logic REG_RADIUS      = 1'b0;
	localparam logic REG_HALF_HEIGHT = 1'b1;

	typedef logic signed [QUAT_W-1:0] quat_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef mag_t [8:0]               mag_mat_t;
	typedef logic [WPROD_W-1:0]       wprod_t;
	typedef logic [EXT_W-1:0]         ext_t;
	typedef logic [MAX_W-1:0]         max_t;
	typedef logic [MIN_W-1:0]         min_t;
	typedef max_t [2:0]               max_vec_t;
	typedef min_t [2:0]               min_vec_t;

	function automatic mag_t mag_of(input logic signed [ENT_W-1:0] e);
		logic signed [ENT_W-1:0] n;
		n = -e;
		return e[ENT_W-1] ? n[MAG_W-1:0] : e[MAG_W-1:0];
	endfunction

	// drop the fraction of the weighted sum and clamp to the output range
	function automatic max_t sat_shift(input logic [SUM_W-1:0] s);
		logic [SHIFT_W-1:0] t;
		t = s[SUM_W-1:FRAC_W];
		return (t > SHIFT_W'(MAX_OUT)) ? MAX_OUT : t[MAX_W-1:0];
	endfunction

endpackage

// File: rtl/rbaabb_quat_mat.sv
// quaternion to absolute rotation matrix, three pipeline stages
module rbaabb_quat_mat (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   in_rot,
	input  rbaabb_pkg::quat_t      in_x,
	input  rbaabb_pkg::quat_t      in_y,
	input  rbaabb_pkg::quat_t      in_z,
	input  rbaabb_pkg::quat_t      in_w,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_rot,
	output rbaabb_pkg::mag_mat_t   out_mag
);
	import rbaabb_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;
	logic rot_s1, rot_s2, rot_s3;
	quat_t x_s1, y_s1, z_s1, w_s1;
	prod_t xx_s2, yy_s2, zz_s2, xy_s2, xz_s2, yz_s2, wx_s2, wy_s2, wz_s2;
	mag_mat_t mag_s3;
	logic signed [ENT_W-1:0] ent [9];

	assign adv_s3   = !v_s3 || out_ready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rot_s1 <= in_rot;
			x_s1   <= in_x;
			y_s1   <= in_y;
			z_s1   <= in_z;
			w_s1   <= in_w;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			rot_s2 <= rot_s1;
			xx_s2  <= PROD_W'(x_s1) * PROD_W'(x_s1);
			yy_s2  <= PROD_W'(y_s1) * PROD_W'(y_s1);
			zz_s2  <= PROD_W'(z_s1) * PROD_W'(z_s1);
			xy_s2  <= PROD_W'(x_s1) * PROD_W'(y_s1);
			xz_s2  <= PROD_W'(x_s1) * PROD_W'(z_s1);
			yz_s2  <= PROD_W'(y_s1) * PROD_W'(z_s1);
			wx_s2  <= PROD_W'(w_s1) * PROD_W'(x_s1);
			wy_s2  <= PROD_W'(w_s1) * PROD_W'(y_s1);
			wz_s2  <= PROD_W'(w_s1) * PROD_W'(z_s1);
		end
	end

	// matrix entries in Q.28, row major
	always_comb begin
		ent[0] = ENT_ONE - ((ENT_W'(yy_s2) + ENT_W'(zz_s2)) <<< 1);
		ent[1] = (ENT_W'(xy_s2) - ENT_W'(wz_s2)) <<< 1;
		ent[2] = (ENT_W'(xz_s2) + ENT_W'(wy_s2)) <<< 1;
		ent[3] = (ENT_W'(xy_s2) + ENT_W'(wz_s2)) <<< 1;
		ent[4] = ENT_ONE - ((ENT_W'(xx_s2) + ENT_W'(zz_s2)) <<< 1);
		ent[5] = (ENT_W'(yz_s2) - ENT_W'(wx_s2)) <<< 1;
		ent[6] = (ENT_W'(xz_s2) - ENT_W'(wy_s2)) <<< 1;
		ent[7] = (ENT_W'(yz_s2) + ENT_W'(wx_s2)) <<< 1;
		ent[8] = ENT_ONE - ((ENT_W'(xx_s2) + ENT_W'(yy_s2)) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			rot_s3 <= rot_s2;
			for (int i = 0; i < 9; i++) begin
				mag_s3[i] <= mag_of(ent[i]);
			end
		end
	end

	assign out_valid = v_s3;
	assign out_rot   = rot_s3;
	assign out_mag   = mag_s3;

endmodule

// File: rtl/rbaabb_axis_sum.sv
// extent weighting and per-axis sum with saturation, two pipeline stages
module rbaabb_axis_sum (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   in_rot,
	input  rbaabb_pkg::mag_mat_t   in_mag,
	input  rbaabb_pkg::ext_t       radius,
	input  rbaabb_pkg::ext_t       half_height,
	output logic                   out_valid,
	input  logic                   out_ready,
	output rbaabb_pkg::max_vec_t   out_max,
	output rbaabb_pkg::min_vec_t   out_min
);
	import rbaabb_pkg::*;

	logic v_s4, v_s5;
	logic adv_s4, adv_s5;
	logic rot_s4;
	wprod_t wp_s4 [9];
	max_vec_t max_s5;
	min_vec_t min_s5;
	max_vec_t max_d;

	assign adv_s5   = !v_s5 || out_ready;
	assign adv_s4   = !v_s4 || adv_s5;
	assign in_ready = adv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv_s4) v_s4 <= in_valid;
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	// the middle column weights by half-height, the outer ones by radius
	always_ff @(posedge clk) begin
		if (adv_s4) begin
			rot_s4 <= in_rot;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					wp_s4[r*3+c] <= WPROD_W'(in_mag[r*3+c]) *
						WPROD_W'((c == 1) ? half_height : radius);
				end
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			if (rot_s4) begin
				max_d[r] = sat_shift(SUM_W'(wp_s4[r*3]) + SUM_W'(wp_s4[r*3+1]) +
					SUM_W'(wp_s4[r*3+2]));
			end else begin
				max_d[r] = MAX_W'((r == 1) ? half_height : radius);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			for (int r = 0; r < 3; r++) begin
				max_s5[r] <= max_d[r];
				min_s5[r] <= MIN_W'(0) - MIN_W'(max_d[r]);
			end
		end
	end

	assign out_valid = v_s5;
	assign out_max   = max_s5;
	assign out_min   = min_s5;

endmodule

// File: rtl/rotated_box_aabb_extents.sv
// top level: quaternion oriented cylinder box to axis-aligned box
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tuser has_rotation, s_tdata quat x,y,z,w
//  m_      | out       | m_tvalid/m_tready  | m_tdata min xyz, max xyz
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (radius, half_height)
//
// five register stages: input, products, matrix magnitudes, extent weighting, sum and clamp
// one transfer per cycle in while the output is not stalled; an accepted item passes
// through the input, product, magnitude, weighting and sum registers before m_tvalid rises
// a stalled output holds its stage and fills the bubbles behind it; nothing is dropped
// reset clears the stage valid bits and sets radius and half_height to 1.0
// cfg_ready is always high
module rotated_box_aabb_extents (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// quat_x, quat_y, quat_z, quat_w
	input  logic [rbaabb_pkg::IN_DATA_W-1:0]  s_tdata,
	// has_rotation
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// min_x, min_y, min_z, max_x, max_y, max_z, zero pad
	output logic [rbaabb_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  rbaabb_pkg::ext_t                  cfg_data
);
	import rbaabb_pkg::*;

	ext_t radius_q, half_height_q;
	logic mat_valid, mat_ready, mat_rot;
	mag_mat_t mat_mag;
	max_vec_t box_max;
	min_vec_t box_min;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= EXT_RESET;
			half_height_q <= EXT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RADIUS:      radius_q      <= cfg_data;
				REG_HALF_HEIGHT: half_height_q <= cfg_data;
			endcase
		end
	end

	rbaabb_quat_mat u_mat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_rot    (s_tuser),
		.in_x      (s_tdata[QUAT_W-1:0]),
		.in_y      (s_tdata[2*QUAT_W-1:QUAT_W]),
		.in_z      (s_tdata[3*QUAT_W-1:2*QUAT_W]),
		.in_w      (s_tdata[4*QUAT_W-1:3*QUAT_W]),
		.out_valid (mat_valid),
		.out_ready (mat_ready),
		.out_rot   (mat_rot),
		.out_mag   (mat_mag)
	);

	rbaabb_axis_sum u_sum (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (mat_valid),
		.in_ready    (mat_ready),
		.in_rot      (mat_rot),
		.in_mag      (mat_mag),
		.radius      (radius_q),
		.half_height (half_height_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_max     (box_max),
		.out_min     (box_min)
	);

	assign m_tdata = {(OUT_DATA_W - OUT_FLDS_W)'(0),
		box_max[2], box_max[1], box_max[0],
		box_min[2], box_min[1], box_min[0]};

endmodule

// File: rtl/rbaabb_checker.sv
// port-level checks for the rotated box to aabb block, bound to the top level
module rbaabb_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [rbaabb_pkg::OUT_DATA_W-1:0] m_tdata
);
	import rbaabb_pkg::*;

	// min field is the exact negation of the max field on every axis
	a_min_neg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (MIN_W'(m_tdata[MIN_W-1:0]) + MIN_W'(m_tdata[3*MIN_W +: MAX_W])) == '0 &&
			(MIN_W'(m_tdata[MIN_W +: MIN_W]) +
				MIN_W'(m_tdata[3*MIN_W+MAX_W +: MAX_W])) == '0 &&
			(MIN_W'(m_tdata[2*MIN_W +: MIN_W]) +
				MIN_W'(m_tdata[3*MIN_W+2*MAX_W +: MAX_W])) == '0)
		else $error("min field does not mirror max field");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_FLDS_W] == '0)
		else $error("output padding not zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output transfer changed");

	// with the output taken meanwhile, an accepted item shows at m_tvalid once it clears the pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(s_tvalid && s_tready, 5) && $past(arst_n, 1) && $past(arst_n, 2) &&
			$past(arst_n, 3) && $past(arst_n, 4) && $past(arst_n, 5) &&
			$past(m_tready, 1) && $past(m_tready, 2) && $past(m_tready, 3) &&
			$past(m_tready, 4) |-> m_tvalid)
		else $error("result missing after pipeline latency");

endmodule

bind rotated_box_aabb_extents rbaabb_checker u_rbaabb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: verif/tb_rotated_box_aabb_extents.sv
`timescale 1ns / 1ps
// testbench for the rotated box to aabb block: random and directed quaternions checked against a scoreboard
module tb_rotated_box_aabb_extents;
	import rbaabb_pkg::*;

	typedef longint unsigned u64_t;

	typedef struct packed {
		min_vec_t mn;
		max_vec_t mx;
	} box_t;

	// tracks the extents registers and the boxes still owed by the block
	class aabb_board;
		ext_t radius_q;
		ext_t half_height_q;
		box_t pending_boxes[$];
		int unsigned fails;

		function new();
			radius_q = EXT_RESET;
			half_height_q = EXT_RESET;
			fails = 0;
		endfunction

		function void write_reg(logic idx, ext_t v);
			if (idx == REG_RADIUS) begin
				radius_q = v;
			end else begin
				half_height_q = v;
			end
		endfunction

		function int pending();
			return pending_boxes.size();
		endfunction

		function u64_t mag(longint v);
			return (v < 0) ? u64_t'(-v) : u64_t'(v);
		endfunction

		// one row of |R| weighted by (radius, half_height, radius), truncated and clamped
		function max_t half_width(longint a, longint b, longint c);
			u64_t s;
			s = mag(a) * u64_t'(radius_q) + mag(b) * u64_t'(half_height_q)
				+ mag(c) * u64_t'(radius_q);
			s = s >> FRAC_W;
			return (s > u64_t'(MAX_OUT)) ? MAX_OUT : max_t'(s);
		endfunction

		function void note_input(bit rot, logic [IN_DATA_W-1:0] q);
			quat_t qc[4];
			longint x, y, z, w, one;
			max_vec_t hw;
			box_t b;
			int i;
			for (i = 0; i < 4; i++) begin
				qc[i] = q[i*QUAT_W +: QUAT_W];
			end
			x = qc[0];
			y = qc[1];
			z = qc[2];
			w = qc[3];
			one = longint'(1) << FRAC_W;
			if (!rot) begin
				hw[0] = max_t'(radius_q);
				hw[1] = max_t'(half_height_q);
				hw[2] = max_t'(radius_q);
			end else begin
				hw[0] = half_width(one - 2 * (y*y + z*z), 2 * (x*y - w*z), 2 * (x*z + w*y));
				hw[1] = half_width(2 * (x*y + w*z), one - 2 * (x*x + z*z), 2 * (y*z - w*x));
				hw[2] = half_width(2 * (x*z - w*y), 2 * (y*z + w*x), one - 2 * (x*x + y*y));
			end
			for (i = 0; i < 3; i++) begin
				b.mx[i] = hw[i];
				b.mn[i] = min_t'(0) - min_t'(hw[i]);
			end
			pending_boxes.push_back(b);
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] d);
			box_t e;
			min_t got_mn;
			max_t got_mx;
			int i;
			if (pending_boxes.size() == 0) begin
				fails++;
				$display("%0t: box transfer with none outstanding, data %h", $time, d);
				return;
			end
			e = pending_boxes.pop_front();
			for (i = 0; i < 3; i++) begin
				got_mn = d[i*MIN_W +: MIN_W];
				got_mx = d[3*MIN_W + i*MAX_W +: MAX_W];
				if (got_mn !== e.mn[i]) begin
					fails++;
					$display("%0t: min[%0d] expected %0d got %0d", $time, i,
						$signed(e.mn[i]), $signed(got_mn));
				end
				if (got_mx !== e.mx[i]) begin
					fails++;
					$display("%0t: max[%0d] expected %0d got %0d", $time, i,
						e.mx[i], got_mx);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	ext_t                  cfg_data;

	aabb_board board;
	bit        tight;

	rotated_box_aabb_extents u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_result(m_tdata);
		end
	end

	// output back-pressure: bursts of always ready, light stall, heavy stall or full stall
	initial begin
		int burst;
		int mode;
		m_tready <= 1'b0;
		forever begin
			burst = $urandom_range(1, 30);
			mode = $urandom_range(0, 5);
			repeat (burst) begin
				@(posedge clk);
				case (mode)
					0, 1: m_tready <= 1'b1;
					2, 3: m_tready <= ($urandom_range(0, 3) != 0);
					4: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= 1'b0;
				endcase
			end
		end
	end

	task automatic idle_gap();
		int n;
		int pick;
		pick = $urandom_range(0, 19);
		if (tight || pick < 10) begin
			n = 0;
		end else if (pick < 18) begin
			n = $urandom_range(1, 3);
		end else begin
			n = $urandom_range(5, 30);
		end
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_box(bit rot, quat_t qx, quat_t qy, quat_t qz, quat_t qw);
		s_tvalid <= 1'b1;
		s_tuser <= rot;
		s_tdata <= {qw, qz, qy, qx};
		do @(posedge clk); while (!s_tready);
		board.note_input(rot, {qw, qz, qy, qx});
		idle_gap();
	endtask

	task automatic write_reg(logic idx, ext_t v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every owed box, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic quat_t rand_comp();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			return quat_t'($urandom);
		end else if (pick < 8) begin
			return quat_t'(int'($urandom_range(0, 32768)) - 16384);
		end
		case ($urandom_range(0, 6))
			0: return quat_t'(-32768);
			1: return quat_t'(-16384);
			2: return quat_t'(-1);
			3: return quat_t'(0);
			4: return quat_t'(1);
			5: return quat_t'(16384);
			default: return quat_t'(32767);
		endcase
	endfunction

	function automatic ext_t rand_ext();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return ext_t'($urandom_range(0, 4096));
			default: return ext_t'($urandom);
		endcase
	endfunction

	task automatic directed_boxes();
		// quaternion ignored when rotation is off
		send_box(1'b0, -32768, 32767, 12345, -1);
		send_box(1'b1, 0, 0, 0, 16384);
		send_box(1'b1, 16384, 0, 0, 0);
		send_box(1'b1, 0, 16384, 0, 0);
		send_box(1'b1, 0, 0, 16384, 0);
		send_box(1'b1, 11585, 0, 0, 11585);
		send_box(1'b1, 0, 11585, 0, 11585);
		send_box(1'b1, 8192, 8192, 8192, 8192);
		// non-unit quaternions, most negative code included
		send_box(1'b1, -16384, -16384, -16384, -16384);
		send_box(1'b1, -32768, -32768, -32768, -32768);
		send_box(1'b1, 32767, -32768, 32767, -32768);
		send_box(1'b1, 0, 0, 0, 0);
	endtask

	initial begin
		int p;
		ext_t r_set;
		ext_t h_set;
		board = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_RADIUS;
		cfg_data <= '0;
		tight = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_boxes();
		drain();
		// largest extents drive the sums of the large non-unit quaternions into saturation
		write_reg(REG_RADIUS, '1);
		write_reg(REG_HALF_HEIGHT, '1);
		directed_boxes();
		drain();

		for (p = 0; p < 6; p++) begin
			case (p)
				0: begin r_set = '0; h_set = '0; end
				1: begin r_set = '1; h_set = '0; end
				2: begin r_set = '0; h_set = '1; end
				default: begin r_set = rand_ext(); h_set = rand_ext(); end
			endcase
			write_reg(REG_RADIUS, r_set);
			write_reg(REG_HALF_HEIGHT, h_set);
			tight = (p == 3);
			repeat (75) begin
				send_box($urandom_range(0, 6) != 0, rand_comp(), rand_comp(),
					rand_comp(), rand_comp());
			end
			drain();
		end

		if (board.fails == 0 && board.pending() == 0) begin
			$display("rotated_box_aabb_extents: match");
		end else begin
			$display("rotated_box_aabb_extents: mismatch");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("rotated_box_aabb_extents: mismatch");
		$finish;
	end

endmodule
